### design/circular_motion_log_stack_core_assert.svh
// assertion macros used by the checker file
`ifndef CIRCULAR_MOTION_LOG_STACK_CORE_ASSERT_SVH
`define CIRCULAR_MOTION_LOG_STACK_CORE_ASSERT_SVH

// checked only while out of reset
`define CMLS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CMLS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/cmls_pkg.sv
// types and constants of the circular motion log stack
package cmls_pkg;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned TIME_W  = 15;
    localparam int unsigned COUNT_W = 10;

    localparam logic [TIME_W-1:0] UNDERFLOW_TIME = TIME_W'(1000);
    localparam logic [TIME_W-1:0] TIME_MAX       = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

endpackage

### design/circular_motion_log_stack_core.sv
// circular overwriting stack of motion records with replay countdown
// result: an accepted word's result is in the output register in the next cycle
// throughput: one word per cycle unless the output stalls; the top record lives in
//   registers, the one below is prefetched by the ring memory's registered read port
// reset: i_rst_n synchronous active low; clears index, count, countdown, mode and
//   output valid; ring contents are not cleared, so no clearing pass is needed
module circular_motion_log_stack_core #(
    parameter int unsigned DEPTH = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_wr_data,
    // input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_command,
    input  logic signed [cmls_pkg::WORD_W-1:0]  i_speed_in,
    input  logic signed [cmls_pkg::WORD_W-1:0]  i_angle_in,
    // output channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [cmls_pkg::WORD_W-1:0]  o_speed_out,
    output logic signed [cmls_pkg::WORD_W-1:0]  o_angle_out,
    output logic [cmls_pkg::TIME_W-1:0]         o_time_out,
    output logic                                o_underflow,
    output logic [cmls_pkg::COUNT_W-1:0]        o_valid_count,
    output logic                                o_countdown_done
);
    import cmls_pkg::*;

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // ring memories: speed/angle written at the new top on push,
    // time written back at the old top when a push covers it
    logic [WORD_W-1:0] mem_speed [DEPTH];
    logic [WORD_W-1:0] mem_angle [DEPTH];
    logic [TIME_W-1:0] mem_time  [DEPTH];

    // control state
    logic [IDX_W-1:0]  r_top,       n_top;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic [TIME_W-1:0] r_countdown, n_countdown;
    logic              r_replay;

    // top record held in registers
    logic [WORD_W-1:0] r_top_speed, n_top_speed;
    logic [WORD_W-1:0] r_top_angle, n_top_angle;
    logic [TIME_W-1:0] r_top_time,  n_top_time;

    // prefetched record just below the top (registered memory read)
    logic [WORD_W-1:0] r_bel_speed;
    logic [WORD_W-1:0] r_bel_angle;
    logic [TIME_W-1:0] r_bel_time;

    // result register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_speed_out, n_speed_out;
    logic [WORD_W-1:0] r_angle_out, n_angle_out;
    logic [TIME_W-1:0] r_time_out,  n_time_out;
    logic              r_uf_out,    n_uf_out;
    logic [CNT_W-1:0]  r_cnt_out;
    logic              r_done_out;

    logic              accept;
    logic              push_acc;
    logic [IDX_W-1:0]  up_idx;
    logic [IDX_W-1:0]  dn_idx;
    logic [IDX_W-1:0]  rd_addr;
    logic              not_empty;

    // the result register frees up as soon as downstream takes its word
    assign o_ready  = !r_out_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign push_acc = accept && (t_cmd'(i_command) == CMD_PUSH);

    assign not_empty = (r_count != '0);
    assign up_idx    = (r_top == LAST_IDX) ? '0 : r_top + 1'b1;
    assign dn_idx    = (r_top == '0) ? LAST_IDX : r_top - 1'b1;

    always_comb begin
        n_top       = r_top;
        n_count     = r_count;
        n_countdown = r_countdown;
        n_top_speed = r_top_speed;
        n_top_angle = r_top_angle;
        n_top_time  = r_top_time;
        n_speed_out = '0;
        n_angle_out = '0;
        n_time_out  = '0;
        n_uf_out    = 1'b0;
        if (accept) begin
            unique case (t_cmd'(i_command))
                CMD_PUSH: begin
                    n_top       = up_idx;
                    n_top_speed = i_speed_in;
                    n_top_angle = i_angle_in;
                    n_top_time  = '0;
                    if (r_count != FULL_CNT) begin
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_POP: begin
                    if (not_empty) begin
                        n_speed_out = r_top_speed;
                        n_angle_out = r_top_angle;
                        n_time_out  = r_top_time;
                        // record below becomes the new top
                        n_top       = dn_idx;
                        n_count     = r_count - 1'b1;
                        n_top_speed = r_bel_speed;
                        n_top_angle = r_bel_angle;
                        n_top_time  = r_bel_time;
                    end else begin
                        n_time_out = UNDERFLOW_TIME;
                        n_uf_out   = 1'b1;
                    end
                    if (r_replay) begin
                        n_countdown = n_time_out;
                    end
                end
                CMD_TICK: begin
                    if (!r_replay) begin
                        // extend the top record, saturating, only when one exists
                        if (not_empty && (r_top_time != TIME_MAX)) begin
                            n_top_time = r_top_time + 1'b1;
                        end
                    end else if (r_countdown != '0) begin
                        n_countdown = r_countdown - 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    n_top   = '0;
                    n_count = '0;
                end
                default: begin
                    n_top = r_top;
                end
            endcase
        end
    end

    // prefetch address: the slot under next cycle's top
    assign rd_addr = (n_top == '0) ? LAST_IDX : n_top - 1'b1;

    // ring memory write and registered read
    always_ff @(posedge i_clk) begin
        if (push_acc) begin
            mem_speed[up_idx] <= i_speed_in;
            mem_angle[up_idx] <= i_angle_in;
            mem_time[r_top]   <= r_top_time;
        end
        r_bel_speed <= mem_speed[rd_addr];
        r_bel_angle <= mem_angle[rd_addr];
        // on push the slot below is the old top whose time is written this cycle
        if (push_acc) begin
            r_bel_time <= r_top_time;
        end else begin
            r_bel_time <= mem_time[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_count     <= '0;
            r_countdown <= '0;
            r_replay    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_top       <= n_top;
            r_count     <= n_count;
            r_countdown <= n_countdown;
            if (i_cfg_wr_en) begin
                r_replay <= i_cfg_wr_data;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // top record and result payload
    always_ff @(posedge i_clk) begin
        r_top_speed <= n_top_speed;
        r_top_angle <= n_top_angle;
        r_top_time  <= n_top_time;
        if (accept) begin
            r_speed_out <= n_speed_out;
            r_angle_out <= n_angle_out;
            r_time_out  <= n_time_out;
            r_uf_out    <= n_uf_out;
            r_cnt_out   <= n_count;
            r_done_out  <= (n_countdown == '0);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_speed_out      = r_speed_out;
    assign o_angle_out      = r_angle_out;
    assign o_time_out       = r_time_out;
    assign o_underflow      = r_uf_out;
    // count reported modulo the 10-bit field
    assign o_valid_count    = COUNT_W'(r_cnt_out);
    assign o_countdown_done = r_done_out;

endmodule

### design/cmls_checker.sv
// port-level checker for the circular motion log stack, bound to the top level
`include "circular_motion_log_stack_core_assert.svh"

module cmls_checker #(
    parameter int unsigned DEPTH = 512
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_wr_en,
    input logic                                i_cfg_wr_data,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic [1:0]                          i_command,
    input logic signed [cmls_pkg::WORD_W-1:0]  i_speed_in,
    input logic signed [cmls_pkg::WORD_W-1:0]  i_angle_in,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic signed [cmls_pkg::WORD_W-1:0]  o_speed_out,
    input logic signed [cmls_pkg::WORD_W-1:0]  o_angle_out,
    input logic [cmls_pkg::TIME_W-1:0]         o_time_out,
    input logic                                o_underflow,
    input logic [cmls_pkg::COUNT_W-1:0]        o_valid_count,
    input logic                                o_countdown_done
);
    import cmls_pkg::*;

    // stalled result stays valid with its time and count unchanged
    `CMLS_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_time_out) && $stable(o_valid_count), "result word changed while stalled")

    // underflow word carries the fixed record
    `CMLS_ASSERT(a_uf_word, i_clk, i_rst_n, o_valid && o_underflow |-> o_speed_out == '0 && o_angle_out == '0 && o_time_out == UNDERFLOW_TIME, "bad underflow word")

    // count never passes the ring depth
    `CMLS_ASSERT(a_count_max, i_clk, i_rst_n, o_valid |-> (DEPTH > 1023) || (o_valid_count <= DEPTH), "valid count beyond depth")

    // no result on the edge after a reset edge
    `CMLS_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind circular_motion_log_stack_core cmls_checker #(.DEPTH(DEPTH)) u_cmls_checker (.*);

### dv/tb_circular_motion_log_stack_core.sv
// testbench for the circular motion log stack: predicting scoreboard and stimulus
`timescale 1ns / 1ps

import cmls_pkg::*;

typedef struct packed {
    logic signed [WORD_W-1:0]  speed;
    logic signed [WORD_W-1:0]  angle;
    logic [TIME_W-1:0]         elapsed;
    logic                      underflow;
    logic [COUNT_W-1:0]        count;
    logic                      done;
} t_motion_result;

class motion_log_scoreboard #(int unsigned DEPTH = 512);
    localparam int unsigned IDX_W = $clog2(DEPTH);

    logic signed [WORD_W-1:0]  ring_speed   [DEPTH];
    logic signed [WORD_W-1:0]  ring_angle   [DEPTH];
    logic [TIME_W-1:0]         ring_elapsed [DEPTH];
    logic [IDX_W-1:0]          top_slot;
    logic [IDX_W:0]            live_count;
    logic [TIME_W-1:0]         countdown;
    logic                      replay;
    t_motion_result            expected_q [$];
    int                        errors;

    function new();
        top_slot   = '0;
        live_count = '0;
        countdown  = '0;
        replay     = 1'b0;
        errors     = 0;
    endfunction

    function void set_replay(logic mode);
        replay = mode;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // advance the log by one accepted word and queue the record it returns
    function void note_word(t_cmd cmd, logic signed [WORD_W-1:0] spd,
                            logic signed [WORD_W-1:0] ang);
        t_motion_result r;
        r = '0;
        case (cmd)
            CMD_PUSH: begin
                top_slot = (top_slot == IDX_W'(DEPTH - 1)) ? '0 : top_slot + 1'b1;
                ring_speed[top_slot]   = spd;
                ring_angle[top_slot]   = ang;
                ring_elapsed[top_slot] = '0;
                if (live_count < DEPTH) live_count = live_count + 1'b1;
            end
            CMD_POP: begin
                if (live_count != 0) begin
                    r.speed   = ring_speed[top_slot];
                    r.angle   = ring_angle[top_slot];
                    r.elapsed = ring_elapsed[top_slot];
                    top_slot  = (top_slot == '0) ? IDX_W'(DEPTH - 1) : top_slot - 1'b1;
                    live_count = live_count - 1'b1;
                end else begin
                    r.elapsed   = UNDERFLOW_TIME;
                    r.underflow = 1'b1;
                end
                if (replay) countdown = r.elapsed;
            end
            CMD_TICK: begin
                if (!replay) begin
                    if (live_count != 0 && ring_elapsed[top_slot] != TIME_MAX)
                        ring_elapsed[top_slot] = ring_elapsed[top_slot] + 1'b1;
                end else if (countdown != 0) begin
                    countdown = countdown - 1'b1;
                end
            end
            default: begin
                top_slot   = '0;
                live_count = '0;
            end
        endcase
        r.count = COUNT_W'(live_count);
        r.done  = (countdown == 0);
        expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] want,
                                logic [WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_word(t_motion_result got);
        t_motion_result want;
        if (expected_q.size() == 0) begin
            $display("%0t: result word with nothing expected, actual %h", $time, got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        compare_field("speed_out", want.speed, got.speed);
        compare_field("angle_out", want.angle, got.angle);
        compare_field("time_out", want.elapsed, got.elapsed);
        compare_field("underflow", want.underflow, got.underflow);
        compare_field("valid_count", want.count, got.count);
        compare_field("countdown_done", want.done, got.done);
    endfunction
endclass

module tb_circular_motion_log_stack_core;

    localparam int unsigned LOG_DEPTH      = 512;
    localparam int          WATCHDOG_LIMIT = 1000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_wr_en = 1'b0;
    logic                       i_cfg_wr_data = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [1:0]                 i_command = CMD_PUSH;
    logic signed [WORD_W-1:0]   i_speed_in = '0;
    logic signed [WORD_W-1:0]   i_angle_in = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic signed [WORD_W-1:0]   o_speed_out;
    logic signed [WORD_W-1:0]   o_angle_out;
    logic [TIME_W-1:0]          o_time_out;
    logic                       o_underflow;
    logic [COUNT_W-1:0]         o_valid_count;
    logic                       o_countdown_done;

    motion_log_scoreboard #(LOG_DEPTH) sb;

    int          burst_left = 0;
    int          idle_cycles = 0;
    int          ready_style = 0;
    int          ready_left = 0;
    logic [7:0]  ready_tick = '0;

    circular_motion_log_stack_core #(
        .DEPTH (LOG_DEPTH)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_speed_in       (i_speed_in),
        .i_angle_in       (i_angle_in),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_speed_out      (o_speed_out),
        .o_angle_out      (o_angle_out),
        .o_time_out       (o_time_out),
        .o_underflow      (o_underflow),
        .o_valid_count    (o_valid_count),
        .o_countdown_done (o_countdown_done)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // receiver: switches between always ready, random, periodic and heavy stalls
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_style <= $urandom_range(0, 3);
            ready_left  <= $urandom_range(16, 160);
        end else begin
            ready_left <= ready_left - 1;
        end
        ready_tick <= ready_tick + 1'b1;
        case (ready_style)
            0:       i_ready <= 1'b1;
            1:       i_ready <= ($urandom_range(0, 99) < 70);
            2:       i_ready <= (ready_tick[2:0] < 3'd3);
            default: i_ready <= ($urandom_range(0, 99) < 25);
        endcase
    end

    // monitor: input words are noted before results are checked so that a
    // result can never overtake its own word; values read here are those
    // in effect at the edge, since everything is driven with nonblocking writes
    always @(posedge i_clk) begin
        t_motion_result got;
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_word(t_cmd'(i_command), i_speed_in, i_angle_in);
                moved = 1'b1;
            end
            if (o_valid && i_ready) begin
                got.speed     = o_speed_out;
                got.angle     = o_angle_out;
                got.elapsed   = o_time_out;
                got.underflow = o_underflow;
                got.count     = o_valid_count;
                got.done      = o_countdown_done;
                sb.check_word(got);
                moved = 1'b1;
            end
            // watchdog on cycles where neither channel moves a word
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return WORD_W'($urandom);
    endfunction

    // command mix: push share given, clear about one in twenty
    function automatic t_cmd pick_command(int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)                     return CMD_PUSH;
        if (r < push_pct + (95 - push_pct) / 2) return CMD_POP;
        if (r < 95)                           return CMD_TICK;
        return CMD_CLEAR;
    endfunction

    // sender: bursts of random length with random gaps, returns at the
    // edge where the word is taken
    task automatic send_word(input t_cmd cmd, input logic [WORD_W-1:0] spd,
                             input logic [WORD_W-1:0] ang);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_speed_in <= spd;
        i_angle_in <= ang;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // hold the sender until every queued record has come back
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // mode changes only with the block drained
    task automatic write_mode(input logic mode);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_replay(mode);
    endtask

    task automatic run_random(input int count, input int push_pct);
        repeat (count) begin
            // now and then let the pipe run dry mid-stream
            if ($urandom_range(0, 199) == 0) wait_idle();
            send_word(pick_command(push_pct), rand_word(), rand_word());
        end
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: recording mode
        write_mode(1'b0);
        send_word(CMD_POP, 16'h0000, 16'h0000);     // pop on empty log
        send_word(CMD_TICK, 16'hffff, 16'hffff);    // tick on empty log does nothing
        send_word(CMD_CLEAR, 16'h0000, 16'hffff);
        send_word(CMD_PUSH, 16'h8000, 16'h7fff);    // field extremes
        send_word(CMD_TICK, 16'h0000, 16'h0000);
        send_word(CMD_TICK, 16'h0000, 16'h0000);
        send_word(CMD_PUSH, 16'h7fff, 16'h8000);
        send_word(CMD_PUSH, 16'h0000, 16'h0000);
        send_word(CMD_PUSH, 16'hffff, 16'hffff);
        send_word(CMD_TICK, 16'h0000, 16'h0000);
        send_word(CMD_POP, 16'h0000, 16'h0000);
        send_word(CMD_POP, 16'h0000, 16'h0000);
        send_word(CMD_POP, 16'h0000, 16'h0000);
        send_word(CMD_POP, 16'h0000, 16'h0000);
        send_word(CMD_POP, 16'h0000, 16'h0000);     // one pop more than records pushed, underflows
        send_word(CMD_PUSH, 16'h1234, 16'hedcb);
        send_word(CMD_CLEAR, 16'h0000, 16'h0000);
        send_word(CMD_POP, 16'h0000, 16'h0000);     // pop after clear underflows
        send_word(CMD_PUSH, 16'h5555, 16'haaaa);
        send_word(CMD_TICK, 16'h0000, 16'h0000);

        // directed: replay mode, countdown load, run out, hold at zero
        write_mode(1'b1);
        send_word(CMD_POP, 16'h0000, 16'h0000);     // loads countdown with one
        send_word(CMD_TICK, 16'h0000, 16'h0000);
        send_word(CMD_TICK, 16'h0000, 16'h0000);    // countdown stays at zero
        send_word(CMD_POP, 16'h0000, 16'h0000);     // underflow loads 1000
        send_word(CMD_PUSH, 16'h0f0f, 16'hf0f0);
        send_word(CMD_TICK, 16'h0000, 16'h0000);    // counts down, record untouched
        send_word(CMD_POP, 16'h0000, 16'h0000);

        // fill past the depth so the oldest records get overwritten, then unwind a bit
        write_mode(1'b0);
        send_word(CMD_CLEAR, rand_word(), rand_word());
        repeat (LOG_DEPTH + 4) begin
            send_word(CMD_PUSH, rand_word(), rand_word());
            if ($urandom_range(0, 15) == 0) send_word(CMD_TICK, rand_word(), rand_word());
        end
        repeat (24) send_word(CMD_POP, rand_word(), rand_word());

        // random mixes in both modes
        write_mode(1'b0);
        run_random(25, 55);
        write_mode(1'b1);
        run_random(25, 45);
        write_mode(1'b0);
        run_random(25, 35);
        write_mode(1'b1);
        run_random(25, 50);

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
